// ===== hdl/ltf_pkg.sv =====
// Shared types, constants and the fade rule for the toroidal life block.
package ltf_pkg;

    localparam int PIX_W = 8;
    localparam int IDX_W = 6;
    localparam logic [PIX_W-1:0] LIVE_PIX = 8'hFF;

    typedef enum logic [1:0] {
        KIND_WRITE   = 2'd0,
        KIND_READ    = 2'd1,
        KIND_ADVANCE = 2'd2
    } kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } state_t;

    // broadcast to every row cell
    typedef struct packed {
        logic             shift_en;
        logic             wr_en;
        logic [IDX_W-1:0] wr_row;
        logic [IDX_W-1:0] wr_col;
        logic [PIX_W-1:0] wr_data;
    } cell_ctl_t;

    // dead cell decay: 255, 173, 91, 9, 0
    function automatic logic [PIX_W-1:0] fade_pix(input logic [PIX_W-1:0] v);
        logic [2:0] f;
        f = (v[2:0] > 3'd1) ? (v[2:0] - 3'd2) : 3'd0;
        return {f[2:1], 6'd0} + 8'({f, 3'b000}) + 8'(f);
    endfunction

endpackage

// ===== hdl/life_torus_step_with_fade.sv =====
// Top level: ring of row cells, one shared row rule unit, request control.
//
//   channel  | valid/ready         | tdata                                  | tuser
//   ---------+---------------------+----------------------------------------+-----------
//   request  | s_tvalid / s_tready | [3:0] col, [7:4] row, [15:8] pixel_in  | [1:0] kind
//   result   | m_tvalid / m_tready | [7:0] pixel_out                        | pixel_live
//
// A write, an out-of-range access or an unknown kind gives its result in the next cycle.
// An in-range read and an advance rotate the row ring once through the head cell,
// where for an advance the rule unit builds each new row in turn; the result is
// registered as the rotation ends.
// Reset clears every pixel directly in each row cell; no clearing pass follows.
// s_tready drops during a ring rotation and while a result waits unaccepted.
module life_torus_step_with_fade #(
    parameter int GRID_WIDTH  = 16,
    parameter int GRID_HEIGHT = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [3:0] col, [7:4] row, [15:8] pixel_in
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] pixel_out
    output logic        m_tuser    // [0] pixel_live
);
    import ltf_pkg::*;

    localparam int ROW_W    = $clog2(GRID_HEIGHT);
    localparam int COL_W    = $clog2(GRID_WIDTH);
    localparam int ROW_BITS = GRID_WIDTH * PIX_W;
    localparam logic [ROW_W-1:0] LAST_STEP = ROW_W'(GRID_HEIGHT - 1);

    logic [ROW_BITS-1:0] cell_row [GRID_HEIGHT];
    logic [ROW_BITS-1:0] tail_in;
    logic [ROW_BITS-1:0] rule_up;
    logic [ROW_BITS-1:0] rule_down;
    logic [ROW_BITS-1:0] rule_new;
    cell_ctl_t           ctl;

    state_t              state_reg,     state_next;
    logic [ROW_W-1:0]    step_reg,      step_next;
    logic                is_adv_reg,    is_adv_next;
    logic                rd_hit_reg,    rd_hit_next;
    logic [ROW_W-1:0]    rd_row_reg,    rd_row_next;
    logic [COL_W-1:0]    rd_col_reg,    rd_col_next;
    logic [PIX_W-1:0]    rd_val_reg,    rd_val_next;
    logic [ROW_BITS-1:0] prev_row_reg,  prev_row_next;
    logic [ROW_BITS-1:0] first_row_reg, first_row_next;
    logic                out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]    out_data_reg,  out_data_next;

    logic [IDX_W-1:0] in_col;
    logic [IDX_W-1:0] in_row;
    logic [PIX_W-1:0] in_pix;
    logic             in_range;
    logic             accept;
    logic             at_row;
    logic [PIX_W-1:0] head_pix;

    assign in_col   = IDX_W'(s_tdata[3:0]);
    assign in_row   = IDX_W'(s_tdata[7:4]);
    assign in_pix   = s_tdata[15:8];
    assign in_range = (7'(in_col) < 7'(GRID_WIDTH)) && (7'(in_row) < 7'(GRID_HEIGHT));
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign head_pix = cell_row[0][rd_col_reg*PIX_W +: PIX_W];
    assign at_row   = rd_hit_reg && (step_reg == rd_row_reg);

    // rows above and below the head; top edge: ring tail, bottom edge: saved first row
    assign rule_up   = (step_reg == '0) ? cell_row[GRID_HEIGHT-1] : prev_row_reg;
    assign rule_down = (step_reg == LAST_STEP) ? first_row_reg : cell_row[1];
    assign tail_in   = is_adv_reg ? rule_new : cell_row[0];

    ltf_row_rule #(
        .GRID_WIDTH (GRID_WIDTH)
    ) u_rule (
        .row_up   (rule_up),
        .row_mid  (cell_row[0]),
        .row_down (rule_down),
        .row_new  (rule_new)
    );

    for (genvar k = 0; k < GRID_HEIGHT; k++) begin : g_cell
        logic [ROW_BITS-1:0] shift_in;
        if (k == GRID_HEIGHT - 1) begin : g_tail
            assign shift_in = tail_in;
        end else begin : g_body
            assign shift_in = cell_row[k+1];
        end
        ltf_row_cell #(
            .GRID_WIDTH (GRID_WIDTH),
            .ROW_IDX    (k)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .shift_in (shift_in),
            .row_out  (cell_row[k])
        );
    end

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        is_adv_next    = is_adv_reg;
        rd_hit_next    = rd_hit_reg;
        rd_row_next    = rd_row_reg;
        rd_col_next    = rd_col_reg;
        rd_val_next    = rd_val_reg;
        prev_row_next  = prev_row_reg;
        first_row_next = first_row_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        ctl.shift_en   = 1'b0;
        ctl.wr_en      = 1'b0;
        ctl.wr_row     = in_row;
        ctl.wr_col     = in_col;
        ctl.wr_data    = in_pix;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (kind_t'(s_tuser))
                        KIND_WRITE: begin
                            ctl.wr_en      = in_range;
                            out_valid_next = 1'b1;
                            out_data_next  = in_range ? in_pix : '0;
                        end
                        KIND_READ: begin
                            if (in_range) begin
                                state_next  = ST_SWEEP;
                                step_next   = '0;
                                is_adv_next = 1'b0;
                                rd_hit_next = 1'b1;
                                rd_row_next = in_row[ROW_W-1:0];
                                rd_col_next = in_col[COL_W-1:0];
                            end else begin
                                out_valid_next = 1'b1;
                                out_data_next  = '0;
                            end
                        end
                        KIND_ADVANCE: begin
                            state_next  = ST_SWEEP;
                            step_next   = '0;
                            is_adv_next = 1'b1;
                            rd_hit_next = 1'b0;
                        end
                        default: begin
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                ctl.shift_en  = 1'b1;
                prev_row_next = cell_row[0];
                if (step_reg == '0) begin
                    first_row_next = cell_row[0];
                end
                if (at_row) begin
                    rd_val_next = head_pix;
                end
                if (step_reg == LAST_STEP) begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    if (is_adv_reg) begin
                        out_data_next = '0;
                    end else begin
                        out_data_next = at_row ? head_pix : rd_val_reg;
                    end
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            is_adv_reg    <= 1'b0;
            rd_hit_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            is_adv_reg    <= is_adv_next;
            rd_hit_reg    <= rd_hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_row_reg    <= rd_row_next;
        rd_col_reg    <= rd_col_next;
        rd_val_reg    <= rd_val_next;
        prev_row_reg  <= prev_row_next;
        first_row_reg <= first_row_next;
        out_data_reg  <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = (out_data_reg == LIVE_PIX);

`ifndef SYNTHESIS
    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> !s_tready)
        else $error("request taken during ring rotation");

    a_sweep_ends_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP && step_reg == LAST_STEP) |=> (m_tvalid && state_reg == ST_IDLE))
        else $error("rotation finished without a result");

    a_step_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> (step_reg <= LAST_STEP))
        else $error("rotation step past last row");

    a_sweep_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && $past(state_reg) == ST_IDLE && state_next == ST_SWEEP)
        |=> (step_reg == '0))
        else $error("rotation did not start at the first row");
`endif

endmodule

// ===== hdl/ltf_row_cell.sv =====
// One row of the frame; shifts to its neighbor in the ring or takes a pixel write.
module ltf_row_cell #(
    parameter int GRID_WIDTH = 16,
    parameter int ROW_IDX    = 0
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  ltf_pkg::cell_ctl_t                       ctl,
    input  logic [GRID_WIDTH*ltf_pkg::PIX_W-1:0]     shift_in,
    output logic [GRID_WIDTH*ltf_pkg::PIX_W-1:0]     row_out
);
    import ltf_pkg::*;

    localparam int COL_W = $clog2(GRID_WIDTH);

    logic [GRID_WIDTH*PIX_W-1:0] row_reg;
    logic [GRID_WIDTH*PIX_W-1:0] row_next;

    always_comb begin
        row_next = row_reg;
        if (ctl.shift_en) begin
            row_next = shift_in;
        end else if (ctl.wr_en && ctl.wr_row == IDX_W'(ROW_IDX)) begin
            row_next[ctl.wr_col[COL_W-1:0]*PIX_W +: PIX_W] = ctl.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
        end else begin
            row_reg <= row_next;
        end
    end

    assign row_out = row_reg;

endmodule

// ===== hdl/ltf_row_rule.sv =====
// Next-generation row from the rows above, at and below, columns wrapping.
module ltf_row_rule #(
    parameter int GRID_WIDTH = 16
) (
    input  logic [GRID_WIDTH*ltf_pkg::PIX_W-1:0] row_up,
    input  logic [GRID_WIDTH*ltf_pkg::PIX_W-1:0] row_mid,
    input  logic [GRID_WIDTH*ltf_pkg::PIX_W-1:0] row_down,
    output logic [GRID_WIDTH*ltf_pkg::PIX_W-1:0] row_new
);
    import ltf_pkg::*;

    logic [GRID_WIDTH-1:0] live_up;
    logic [GRID_WIDTH-1:0] live_mid;
    logic [GRID_WIDTH-1:0] live_down;

    for (genvar x = 0; x < GRID_WIDTH; x++) begin : g_live
        assign live_up[x]   = (row_up[x*PIX_W +: PIX_W] == LIVE_PIX);
        assign live_mid[x]  = (row_mid[x*PIX_W +: PIX_W] == LIVE_PIX);
        assign live_down[x] = (row_down[x*PIX_W +: PIX_W] == LIVE_PIX);
    end

    for (genvar x = 0; x < GRID_WIDTH; x++) begin : g_pix
        localparam int XM = (x == 0) ? GRID_WIDTH - 1 : x - 1;
        localparam int XP = (x == GRID_WIDTH - 1) ? 0 : x + 1;
        logic [3:0] count;
        logic       alive;

        assign count = 4'(live_up[XM]) + 4'(live_up[x]) + 4'(live_up[XP])
                     + 4'(live_mid[XM]) + 4'(live_mid[XP])
                     + 4'(live_down[XM]) + 4'(live_down[x]) + 4'(live_down[XP]);
        assign alive = (count == 4'd3) || (live_mid[x] && count == 4'd2);
        assign row_new[x*PIX_W +: PIX_W] = alive ? LIVE_PIX
                                                 : fade_pix(row_mid[x*PIX_W +: PIX_W]);
    end

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking stream testbench for the toroidal life grid with fading dead cells.
`timescale 1ns / 100ps

module tb;
    import ltf_pkg::*;

    localparam int GRID_W = 16;
    localparam int GRID_H = 16;
    localparam int RANDOM_ITEMS = 850;
    localparam int TAIL_CYCLES = 2 * GRID_H + 8;
    localparam logic [1:0] KIND_VOID = 2'd3;   // unused kind, block must ignore it

    typedef struct {
        logic [1:0]       kind;
        logic [3:0]       col;
        logic [3:0]       row;
        logic [PIX_W-1:0] pix;
    } pix_req_t;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             live;
    } pix_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;     // [3:0] col, [7:4] row, [15:8] pixel_in
    logic [1:0]  s_tuser = '0;     // [1:0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] pixel_out
    logic        m_tuser;          // [0] pixel_live

    // predicted grid contents
    logic [PIX_W-1:0] life_pix [GRID_H][GRID_W];

    pix_req_t    pend_q [$];
    pix_result_t pix_due_q [$];
    pix_req_t    cur_req;

    int err_cnt = 0;
    int sent_cnt = 0;
    int req_total = 0;
    int burst_left = 0;
    int gap_left = 0;
    int rx_cyc = 0;
    int hold_left = 0;

    life_torus_step_with_fade #(
        .GRID_WIDTH  (GRID_W),
        .GRID_HEIGHT (GRID_H)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
        err_cnt++;
    endtask

    // dead cell decay on the low three bits
    function automatic logic [PIX_W-1:0] decay_pix(input logic [PIX_W-1:0] v);
        int low;
        int f;
        low = v & 7;
        f = (low > 1) ? low - 2 : 0;
        return PIX_W'(((f >> 1) << 6) + 9 * f);
    endfunction

    function automatic void advance_frame();
        logic [PIX_W-1:0] nxt [GRID_H][GRID_W];
        int nb;
        for (int y = 0; y < GRID_H; y++) begin
            for (int x = 0; x < GRID_W; x++) begin
                nb = 0;
                for (int dy = -1; dy <= 1; dy++) begin
                    for (int dx = -1; dx <= 1; dx++) begin
                        if ((dx != 0 || dy != 0) &&
                            life_pix[(y + dy + GRID_H) % GRID_H][(x + dx + GRID_W) % GRID_W]
                                == LIVE_PIX)
                            nb++;
                    end
                end
                if (nb == 3 || (nb == 2 && life_pix[y][x] == LIVE_PIX))
                    nxt[y][x] = LIVE_PIX;
                else
                    nxt[y][x] = decay_pix(life_pix[y][x]);
            end
        end
        life_pix = nxt;
    endfunction

    function automatic void apply_request(input pix_req_t r);
        pix_result_t res;
        res.pix = '0;
        case (r.kind)
            KIND_WRITE: begin
                life_pix[r.row][r.col] = r.pix;
                res.pix = r.pix;
            end
            KIND_READ:    res.pix = life_pix[r.row][r.col];
            KIND_ADVANCE: advance_frame();
            default: ;
        endcase
        res.live = (res.pix == LIVE_PIX);
        pix_due_q.push_back(res);
    endfunction

    task automatic queue_req(input logic [1:0] kind, input int col, input int row,
                             input int pix);
        pix_req_t r;
        r.kind = kind;
        r.col = 4'(col);
        r.row = 4'(row);
        r.pix = PIX_W'(pix);
        pend_q.push_back(r);
    endtask

    // sender: bursts of requests separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_request(cur_req);
                sent_cnt++;
            end
            if (s_tvalid && !s_tready) begin
                // hold the offered request
            end else if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pend_q.size() == 0) begin
                s_tvalid <= 1'b0;
            end else begin
                cur_req = pend_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {cur_req.pix, cur_req.row, cur_req.col};
                s_tuser <= cur_req.kind;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end
            end
        end
    end

    // receiver: rotates through four stall patterns, plus two long hold-offs
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_cyc++;
            if (rx_cyc == 3000 || rx_cyc == 9000)
                hold_left = 400;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case ((rx_cyc >> 6) % 4)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= rx_cyc[0];
                endcase
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        pix_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pix_due_q.size() == 0) begin
                report_mismatch("result with no request pending, pixel_out", m_tdata, 0);
            end else begin
                want = pix_due_q.pop_front();
                if (m_tdata !== want.pix)
                    report_mismatch("pixel_out", m_tdata, want.pix);
                if (m_tuser !== want.live)
                    report_mismatch("pixel_live", m_tuser, want.live);
            end
        end
    end

    initial begin
        #500000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int ox;
        int oy;
        int n;
        int counted;
        logic [1:0] k;

        for (int y = 0; y < GRID_H; y++)
            for (int x = 0; x < GRID_W; x++)
                life_pix[y][x] = '0;

        // directed: cleared frame, blinker across the column wrap, odd values, ignored kind
        queue_req(KIND_READ, 0, 0, 0);
        queue_req(KIND_WRITE, 15, 0, 255);
        queue_req(KIND_WRITE, 0, 0, 255);
        queue_req(KIND_WRITE, 1, 0, 255);
        queue_req(KIND_WRITE, 15, 15, 8'h5A);
        queue_req(KIND_WRITE, 8, 8, 8'h07);
        queue_req(KIND_WRITE, 9, 9, 8'hFE);
        queue_req(KIND_WRITE, 4, 12, 8'h00);
        queue_req(KIND_VOID, 15, 15, 255);
        queue_req(KIND_READ, 15, 15, 0);
        queue_req(KIND_ADVANCE, 15, 15, 255);
        queue_req(KIND_READ, 0, 15, 0);
        queue_req(KIND_READ, 0, 0, 0);
        queue_req(KIND_READ, 0, 1, 0);
        queue_req(KIND_READ, 15, 0, 0);
        queue_req(KIND_READ, 8, 8, 0);
        queue_req(KIND_READ, 9, 9, 0);
        queue_req(KIND_READ, 15, 15, 0);
        queue_req(KIND_ADVANCE, 0, 0, 0);
        queue_req(KIND_READ, 1, 0, 0);
        queue_req(KIND_READ, 0, 15, 0);
        queue_req(KIND_ADVANCE, 0, 0, 0);
        queue_req(KIND_READ, 8, 8, 255);
        queue_req(KIND_ADVANCE, 0, 0, 0);
        queue_req(KIND_READ, 0, 1, 0);

        // random: seeded patterns left to evolve, mixed with noise
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 6) begin
                ox = $urandom_range(0, GRID_W - 1);
                oy = $urandom_range(0, GRID_H - 1);
                n = $urandom_range(3, 8);
                for (int i = 0; i < n; i++) begin
                    queue_req(KIND_WRITE, (ox + $urandom_range(0, 3)) % GRID_W,
                              (oy + $urandom_range(0, 3)) % GRID_H,
                              ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : 255);
                end
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    queue_req(KIND_ADVANCE, $urandom_range(0, 15), $urandom_range(0, 15),
                              $urandom_range(0, 255));
                n = $urandom_range(2, 6);
                for (int i = 0; i < n; i++)
                    queue_req(KIND_READ, (ox + $urandom_range(0, 5) + GRID_W - 1) % GRID_W,
                              (oy + $urandom_range(0, 5) + GRID_H - 1) % GRID_H, 0);
            end else begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    k = 2'($urandom_range(0, 3));
                    queue_req(k, $urandom_range(0, 15), $urandom_range(0, 15),
                              $urandom_range(0, 255));
                    if (k == KIND_VOID)
                        counted--;
                end
            end
            counted = pend_q.size() - 1 + counted - (pend_q.size() - 1);
            counted = 0;
            foreach (pend_q[i])
                if (pend_q[i].kind != KIND_VOID)
                    counted++;
            counted -= 24;
        end
        req_total = pend_q.size();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (sent_cnt < req_total)
            @(posedge aclk);
        while (pix_due_q.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pix_due_q.size() != 0)
            report_mismatch("results still missing at end, count", 0, pix_due_q.size());

        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
